// File: rtl/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes and controller/datapath interface types of the positional
// list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int FUNC_W = 3;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 6;

	localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] OP_DELETE = 3'd1;
	localparam logic [FUNC_W-1:0] OP_GET    = 3'd2;
	localparam logic [FUNC_W-1:0] OP_LOCATE = 3'd3;
	localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [2:0] PTR_HOLD     = 3'd0;
	localparam logic [2:0] PTR_LOAD_CNT = 3'd1;
	localparam logic [2:0] PTR_LOAD_POS = 3'd2;
	localparam logic [2:0] PTR_ZERO     = 3'd3;
	localparam logic [2:0] PTR_INC      = 3'd4;
	localparam logic [2:0] PTR_DEC      = 3'd5;

	localparam logic [1:0] RA_PTR_M1 = 2'd0;
	localparam logic [1:0] RA_PTR    = 2'd1;
	localparam logic [1:0] RA_POS_M1 = 2'd2;

	localparam logic [1:0] WA_PTR    = 2'd0;
	localparam logic [1:0] WA_PTR_M1 = 2'd1;
	localparam logic [1:0] WA_POS_M1 = 2'd2;

	localparam logic [1:0] CNT_HOLD  = 2'd0;
	localparam logic [1:0] CNT_INC   = 2'd1;
	localparam logic [1:0] CNT_DEC   = 2'd2;
	localparam logic [1:0] CNT_CLEAR = 2'd3;

	typedef struct packed {
		logic              cap;
		logic [2:0]        ptr_op;
		logic              rd_en;
		logic [1:0]        rd_sel;
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic              data_load;
		logic              found_load;
		logic [1:0]        cnt_op;
		logic              st_load;
		logic [STAT_W-1:0] st_val;
		logic              out_load;
	} ple_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              pos_zero;
		logic              pos_le_cnt;
		logic              pos_le_cnt1;
		logic              full;
		logic              ptr_ge_pos;
		logic              ptr_lt_cnt;
		logic              match;
		logic              out_free;
	} ple_stat_t;

endpackage
`default_nettype wire

// File: rtl/ple_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer that decodes a request and steps the datapath through the
// entry moves, reads and compares that the operation needs.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire ple_pkg::ple_stat_t stat,
	output ple_pkg::ple_cmd_t       cmd
);
	import ple_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_INS_CHK = 4'd2;
	localparam logic [3:0] S_INS_WR  = 4'd3;
	localparam logic [3:0] S_DEL_CAP = 4'd4;
	localparam logic [3:0] S_DEL_CHK = 4'd5;
	localparam logic [3:0] S_DEL_WR  = 4'd6;
	localparam logic [3:0] S_GET_CAP = 4'd7;
	localparam logic [3:0] S_LOC_CHK = 4'd8;
	localparam logic [3:0] S_LOC_CMP = 4'd9;
	localparam logic [3:0] S_RESULT  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd.cap        = 1'b0;
		cmd.ptr_op     = PTR_HOLD;
		cmd.rd_en      = 1'b0;
		cmd.rd_sel     = RA_PTR;
		cmd.wr_en      = 1'b0;
		cmd.wr_sel     = WA_PTR;
		cmd.data_load  = 1'b0;
		cmd.found_load = 1'b0;
		cmd.cnt_op     = CNT_HOLD;
		cmd.st_load    = 1'b0;
		cmd.st_val     = ST_OK;
		cmd.out_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.func)
					OP_INSERT: begin
						if (stat.pos_zero || !stat.pos_le_cnt1) begin
							cmd.st_load = 1'b1;
							cmd.st_val  = ST_RANGE;
							state_d     = S_RESULT;
						end else if (stat.full) begin
							cmd.st_load = 1'b1;
							cmd.st_val  = ST_FULL;
							state_d     = S_RESULT;
						end else begin
							cmd.ptr_op = PTR_LOAD_CNT;
							state_d    = S_INS_CHK;
						end
					end
					OP_DELETE: begin
						if (stat.pos_zero || !stat.pos_le_cnt) begin
							cmd.st_load = 1'b1;
							cmd.st_val  = ST_RANGE;
							state_d     = S_RESULT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_POS_M1;
							cmd.ptr_op = PTR_LOAD_POS;
							state_d    = S_DEL_CAP;
						end
					end
					OP_GET: begin
						if (stat.pos_zero || !stat.pos_le_cnt) begin
							cmd.st_load = 1'b1;
							cmd.st_val  = ST_RANGE;
							state_d     = S_RESULT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_POS_M1;
							state_d    = S_GET_CAP;
						end
					end
					OP_LOCATE: begin
						cmd.ptr_op = PTR_ZERO;
						state_d    = S_LOC_CHK;
					end
					OP_CLEAR: begin
						cmd.cnt_op = CNT_CLEAR;
						state_d    = S_RESULT;
					end
					default: begin
						state_d = S_RESULT;
					end
				endcase
			end
			S_INS_CHK: begin
				if (stat.ptr_ge_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PTR_M1;
					state_d    = S_INS_WR;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WA_POS_M1;
					cmd.cnt_op = CNT_INC;
					state_d    = S_RESULT;
				end
			end
			S_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WA_PTR;
				cmd.ptr_op = PTR_DEC;
				state_d    = S_INS_CHK;
			end
			S_DEL_CAP: begin
				cmd.data_load = 1'b1;
				state_d       = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				if (stat.ptr_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PTR;
					state_d    = S_DEL_WR;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_RESULT;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WA_PTR_M1;
				cmd.ptr_op = PTR_INC;
				state_d    = S_DEL_CHK;
			end
			S_GET_CAP: begin
				cmd.data_load = 1'b1;
				state_d       = S_RESULT;
			end
			S_LOC_CHK: begin
				if (stat.ptr_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PTR;
					state_d    = S_LOC_CMP;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_LOC_CMP: begin
				if (stat.match) begin
					cmd.found_load = 1'b1;
					state_d        = S_RESULT;
				end else begin
					cmd.ptr_op = PTR_INC;
					state_d    = S_LOC_CHK;
				end
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/ple_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_dpath
// Entry store, length counter, walk pointer, request registers and the
// registered result beat of the positional list engine.
// ----------------------------------------------------------------------------
module ple_dpath #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ple_pkg::ple_cmd_t         cmd,
	output ple_pkg::ple_stat_t             stat,
	input  wire logic [ple_pkg::FUNC_W-1:0] in_func,
	input  wire logic [ple_pkg::POS_W-1:0]  in_position,
	input  wire logic [ple_pkg::VAL_W-1:0]  in_value,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [ple_pkg::STAT_W-1:0]     out_status,
	output logic [ple_pkg::VAL_W-1:0]      out_data,
	output logic [ple_pkg::POS_W-1:0]      out_found,
	output logic [ple_pkg::LEN_W-1:0]      out_length,
	output logic                           out_empty
);
	import ple_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [VAL_W-1:0] mem [MAX_ENTRIES];

	logic [FUNC_W-1:0] func_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  val_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     ptr_q;
	logic [VAL_W-1:0]  rdata_q;
	logic [VAL_W-1:0]  data_q;
	logic [POS_W-1:0]  found_q;
	logic [STAT_W-1:0] status_q;

	logic [WW-1:0] pos_w;
	logic [WW-1:0] cnt_w;
	logic [WW-1:0] ptr_w;
	logic [WW-1:0] pos_m1_w;
	logic [WW-1:0] ptr_p1_w;
	logic [CW-1:0] ptr_m1;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;

	assign pos_w    = WW'(pos_q);
	assign cnt_w    = WW'(cnt_q);
	assign ptr_w    = WW'(ptr_q);
	assign pos_m1_w = pos_w - WW'(1);
	assign ptr_p1_w = ptr_w + WW'(1);
	assign ptr_m1   = ptr_q - CW'(1);

	assign stat.func        = func_q;
	assign stat.pos_zero    = (pos_q == '0);
	assign stat.pos_le_cnt  = (pos_w <= cnt_w);
	assign stat.pos_le_cnt1 = (pos_w <= (cnt_w + WW'(1)));
	assign stat.full        = (cnt_q >= CW'(MAX_ENTRIES));
	assign stat.ptr_ge_pos  = (ptr_w >= pos_w);
	assign stat.ptr_lt_cnt  = (ptr_q < cnt_q);
	assign stat.match       = (rdata_q == val_q);
	assign stat.out_free    = !m_tvalid || m_tready;

	always_comb begin
		case (cmd.rd_sel)
			RA_PTR_M1: rd_addr = ptr_m1[AW-1:0];
			RA_PTR:    rd_addr = ptr_q[AW-1:0];
			RA_POS_M1: rd_addr = pos_m1_w[AW-1:0];
			default:   rd_addr = ptr_q[AW-1:0];
		endcase
		case (cmd.wr_sel)
			WA_PTR: begin
				wr_addr = ptr_q[AW-1:0];
				wr_data = rdata_q;
			end
			WA_PTR_M1: begin
				wr_addr = ptr_m1[AW-1:0];
				wr_data = rdata_q;
			end
			WA_POS_M1: begin
				wr_addr = pos_m1_w[AW-1:0];
				wr_data = val_q;
			end
			default: begin
				wr_addr = ptr_q[AW-1:0];
				wr_data = rdata_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q   <= in_func;
			pos_q    <= in_position;
			val_q    <= in_value;
			data_q   <= '0;
			found_q  <= '0;
			status_q <= ST_OK;
		end else begin
			if (cmd.data_load) begin
				data_q <= rdata_q;
			end
			if (cmd.found_load) begin
				found_q <= ptr_p1_w[POS_W-1:0];
			end
			if (cmd.st_load) begin
				status_q <= cmd.st_val;
			end
		end
		case (cmd.ptr_op)
			PTR_LOAD_CNT: ptr_q <= cnt_q;
			PTR_LOAD_POS: ptr_q <= pos_w[CW-1:0];
			PTR_ZERO:     ptr_q <= '0;
			PTR_INC:      ptr_q <= ptr_q + CW'(1);
			PTR_DEC:      ptr_q <= ptr_m1;
			default:      ptr_q <= ptr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC:   cnt_q <= cnt_q + CW'(1);
				CNT_DEC:   cnt_q <= cnt_q - CW'(1);
				CNT_CLEAR: cnt_q <= '0;
				default:   cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= status_q;
			out_data   <= data_q;
			out_found  <= found_q;
			out_length <= cnt_w[LEN_W-1:0];
			out_empty  <= (cnt_q == '0);
		end
	end

endmodule
`default_nettype wire

// File: rtl/positional_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list of signed 32-bit values with 1-based positions:
// insert, delete, get, locate and clear, one result beat per request beat.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result beat
// for it. Entries live in a single-port-write, single-port-read store with a
// registered read, so every moved or examined entry takes a read step and then
// a write or compare step. Insert shifts each entry above the position up by
// one before it writes the value, delete captures the entry and shifts the
// entries above it down, and locate compares entries from position 1 until
// one matches or the list ends. The result sits in its own register, so a new
// request is accepted while the previous result waits for m_tready. A bad
// position gives status 1, a valid insert into a full list gives status 2, and
// unknown operation codes just report the current length.
module positional_list_engine_core #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // func[2:0], position[8:3], value[40:9], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata   // status[1:0], data_out[33:2], found_position[39:34],
	                                   // length[45:40], empty_res[46], zero pad
);
	import ple_pkg::*;

	ple_cmd_t          cmd;
	ple_stat_t         stat;
	logic [STAT_W-1:0] out_status;
	logic [VAL_W-1:0]  out_data;
	logic [POS_W-1:0]  out_found;
	logic [LEN_W-1:0]  out_length;
	logic              out_empty;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ple_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_func     (s_tdata[2:0]),
		.in_position (s_tdata[8:3]),
		.in_value    (s_tdata[40:9]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_status  (out_status),
		.out_data    (out_data),
		.out_found   (out_found),
		.out_length  (out_length),
		.out_empty   (out_empty)
	);

	assign m_tdata = {1'b0, out_empty, out_length, out_found, out_data, out_status};

endmodule
`default_nettype wire
